// ===== hw/rtl/spq_pkg.sv =====
// types, constants and command struct shared by the sorted priority queue
package spq_pkg;

	localparam int DEPTH        = 16;
	localparam int PAYLOAD_BITS = 16;
	localparam int CNT_W        = $clog2(DEPTH + 1);

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic [PAYLOAD_BITS-1:0] pay_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  in_priority;
		logic [15:0] in_payload;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_priority;
		logic [15:0] out_payload;
		logic        now_empty;
		logic [4:0]  occupancy;
	} out_t;

	typedef logic [4:0] occ_t;
	typedef logic [15:0] opay_t;

	typedef struct packed {
		logic [7:0] prio;
		pay_t       payload;
	} entry_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t ent;
	} cmd_t;

endpackage

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// sorted priority queue: handshake, result register and the cell chain
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready  | in_data  (func, in_priority, in_payload)
//  out     | out | out_valid / out_ready| out_data (status, out_priority, out_payload,
//          |     |                      |           now_empty, occupancy)
//
// one item per cycle while in_ready is high: all cells compare against the new priority
// at once and shift in the same cycle, so the chain takes an operation every clock.
// the result sits in a register from the cycle after the input transfer.
// in_ready is low only while a result waits and out_ready is low.
// arst_n clears the count and the result valid; cell contents need no reset.
module sorted_priority_queue_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  spq_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output spq_pkg::out_t out_data
);

	logic            in_fire;
	logic            out_valid_q;
	spq_pkg::out_t   out_q;
	spq_pkg::out_t   res;
	spq_pkg::entry_t head;
	spq_pkg::cnt_t   count;
	spq_pkg::cnt_t   count_d;
	logic            full;
	logic            empty;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	spq_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (in_fire),
		.item    (in_data),
		.head    (head),
		.count   (count),
		.count_d (count_d),
		.full    (full),
		.empty   (empty)
	);

	always_comb begin
		res.status       = spq_pkg::ST_OK;
		res.out_priority = '0;
		res.out_payload  = '0;
		if (in_data.func == spq_pkg::FUNC_ENQ) begin
			if (full) begin
				res.status = spq_pkg::ST_FULL;
			end
		end else if (empty) begin
			res.status = spq_pkg::ST_EMPTY;
		end else begin
			res.out_priority = head.prio;
			res.out_payload  = spq_pkg::opay_t'(head.payload);
		end
		res.now_empty = (count_d == '0);
		res.occupancy = spq_pkg::occ_t'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= spq_pkg::cnt_t'(spq_pkg::DEPTH))
		else $error("entry count above depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == spq_pkg::ST_FULL)
		|-> (out_q.occupancy == spq_pkg::occ_t'(spq_pkg::DEPTH)))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == spq_pkg::ST_EMPTY)
		|-> (out_q.now_empty && (out_q.occupancy == '0) && (out_q.out_priority == '0)))
		else $error("empty status on a non-empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (count == count_d) || (count == $past(count_d)))
		else $error("count did not follow the transfer");
`endif

endmodule

// ===== hw/rtl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell (
	input  logic            clk,
	input  spq_pkg::cmd_t   cmd,
	input  logic            occupied,
	input  logic            prev_keep,
	input  spq_pkg::entry_t prev_ent,
	input  spq_pkg::entry_t next_ent,
	output logic            keep,
	output spq_pkg::entry_t ent
);

	spq_pkg::entry_t ent_q;

	// an occupied slot with priority at least the new one stays in place
	assign keep = occupied && (ent_q.prio >= cmd.ent.prio);
	assign ent  = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.enq && !keep) begin
			// first slot that does not keep takes the new entry, the rest shift back
			ent_q <= prev_keep ? cmd.ent : prev_ent;
		end else if (cmd.deq) begin
			ent_q <= next_ent;
		end
	end

endmodule

// ===== hw/rtl/spq_chain.sv =====
// row of cells plus the occupancy count
module spq_chain (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  spq_pkg::in_t    item,
	output spq_pkg::entry_t head,
	output spq_pkg::cnt_t   count,
	output spq_pkg::cnt_t   count_d,
	output logic            full,
	output logic            empty
);

	spq_pkg::cnt_t   count_q;
	spq_pkg::cmd_t   cmd;
	spq_pkg::entry_t ents [spq_pkg::DEPTH];
	logic            keeps [spq_pkg::DEPTH];

	assign full  = (count_q == spq_pkg::cnt_t'(spq_pkg::DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.enq         = go && (item.func == spq_pkg::FUNC_ENQ) && !full;
		cmd.deq         = go && (item.func == spq_pkg::FUNC_DEQ) && !empty;
		cmd.ent.prio    = item.in_priority;
		cmd.ent.payload = spq_pkg::pay_t'(item.in_payload);
		if (cmd.enq) begin
			count_d = count_q + 1'b1;
		end else if (cmd.deq) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
		logic            prev_keep;
		spq_pkg::entry_t prev_ent;
		spq_pkg::entry_t next_ent;

		if (i == 0) begin : g_first
			assign prev_keep = 1'b1;
			assign prev_ent  = cmd.ent;
		end else begin : g_mid
			assign prev_keep = keeps[i-1];
			assign prev_ent  = ents[i-1];
		end

		if (i == spq_pkg::DEPTH - 1) begin : g_last
			assign next_ent = ents[i];
		end else begin : g_notlast
			assign next_ent = ents[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (spq_pkg::CNT_W'(i) < count_q),
			.prev_keep (prev_keep),
			.prev_ent  (prev_ent),
			.next_ent  (next_ent),
			.keep      (keeps[i]),
			.ent       (ents[i])
		);
	end

	assign head  = ents[0];
	assign count = count_q;

endmodule

// ===== verif/spq_checker.sv =====
// checker for the sorted priority queue: tracks the queue contents and compares every result
`timescale 1ns / 1ps

module spq_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  spq_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  spq_pkg::out_t out_data,
	output int            fail_count,
	output int            pending,
	output int            checked,
	output int            drops,
	output int            underflows
);

	logic [7:0]    slot_prio [spq_pkg::DEPTH];
	spq_pkg::pay_t slot_pay  [spq_pkg::DEPTH];
	int            fill;
	spq_pkg::out_t due_results [$];
	int            errs;
	int            n_checked;
	int            n_drops;
	int            n_under;

	// insert behind every entry of greater or equal priority, pop from the front
	task automatic serve_job(input spq_pkg::in_t op, output spq_pkg::out_t res);
		int pos;
		res = '0;
		res.status = spq_pkg::ST_OK;
		if (op.func == spq_pkg::FUNC_ENQ) begin
			if (fill >= spq_pkg::DEPTH) begin
				res.status = spq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < fill && slot_prio[pos] >= op.in_priority)
					pos++;
				for (int k = fill; k > pos; k--) begin
					slot_prio[k] = slot_prio[k-1];
					slot_pay[k]  = slot_pay[k-1];
				end
				slot_prio[pos] = op.in_priority;
				slot_pay[pos]  = spq_pkg::pay_t'(op.in_payload);
				fill++;
			end
		end else if (fill == 0) begin
			res.status = spq_pkg::ST_EMPTY;
		end else begin
			res.out_priority = slot_prio[0];
			res.out_payload  = slot_pay[0];
			for (int k = 1; k < fill; k++) begin
				slot_prio[k-1] = slot_prio[k];
				slot_pay[k-1]  = slot_pay[k];
			end
			fill--;
		end
		res.now_empty = (fill == 0);
		res.occupancy = spq_pkg::occ_t'(fill);
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		spq_pkg::out_t want;
		spq_pkg::out_t fresh;
		if (!arst_n) begin
			fill = 0;
			errs = 0;
			n_checked = 0;
			n_drops = 0;
			n_under = 0;
			due_results.delete();
			for (int k = 0; k < spq_pkg::DEPTH; k++) begin
				slot_prio[k] = '0;
				slot_pay[k]  = '0;
			end
		end else begin
			// a result always belongs to an earlier input, so it goes first
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing outstanding, got %p", $time, out_data);
					errs++;
				end else begin
					want = due_results.pop_front();
					check_field("status", 16'(want.status), 16'(out_data.status));
					check_field("out_priority", 16'(want.out_priority),
						16'(out_data.out_priority));
					check_field("out_payload", want.out_payload, out_data.out_payload);
					check_field("now_empty", 16'(want.now_empty), 16'(out_data.now_empty));
					check_field("occupancy", 16'(want.occupancy), 16'(out_data.occupancy));
					n_checked++;
				end
			end
			if (in_valid && in_ready) begin
				serve_job(in_data, fresh);
				if (fresh.status == spq_pkg::ST_FULL)
					n_drops++;
				if (fresh.status == spq_pkg::ST_EMPTY)
					n_under++;
				due_results.push_back(fresh);
			end
		end
		fail_count <= errs;
		pending    <= due_results.size();
		checked    <= n_checked;
		drops      <= n_drops;
		underflows <= n_under;
	end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the sorted priority queue: clock, reset, traffic and verdict
`timescale 1ns / 1ps

module tb_top;

	localparam int RAND_ITEMS = 550;
	localparam int STALL_LIMIT = 2000;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	spq_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	spq_pkg::out_t out_data;
	logic          idle_on;

	int fail_count;
	int pending;
	int checked;
	int drops;
	int underflows;
	int n_sent;
	int quiet_cycles;

	sorted_priority_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	spq_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.drops      (drops),
		.underflows (underflows)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side stalls at random unless idling is switched off
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !(idle_on && $urandom_range(99) < 21);
	end

	// ends the run if nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("sorted_priority_queue_top: mismatch");
				$finish;
			end
		end
	end

	task automatic send_op(input logic func, input logic [7:0] prio, input logic [15:0] pay);
		spq_pkg::in_t op;
		op.func        = func;
		op.in_priority = prio;
		op.in_payload  = pay;
		while (idle_on && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= op;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
	endtask

	initial begin
		logic [7:0]  fill_prio [17];
		logic [15:0] fill_pay  [17];
		int          bias;
		int          run_len;
		logic        func;
		logic [7:0]  prio;

		fill_prio = '{8'd0, 8'd255, 8'd10, 8'd10, 8'd10, 8'd255, 8'd0, 8'd128, 8'd1,
			8'd254, 8'd127, 8'd64, 8'd10, 8'd200, 8'd3, 8'd77, 8'd99};
		fill_pay = '{16'h0000, 16'hffff, 16'haaaa, 16'h5555, 16'h0001, 16'h8000,
			16'h1234, 16'hfedc, 16'h0f0f, 16'hf0f0, 16'h7fff, 16'h00ff, 16'hff00,
			16'h3c3c, 16'hc3c3, 16'h0042, 16'hdead};
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		idle_on  <= 1'b1;
		n_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// dequeue from empty, fill past full with ties and extremes, then drain partway
		send_op(spq_pkg::FUNC_DEQ, 8'hff, 16'hffff);
		for (int i = 0; i < 17; i++)
			send_op(spq_pkg::FUNC_ENQ, fill_prio[i], fill_pay[i]);
		repeat (7)
			send_op(spq_pkg::FUNC_DEQ, 8'h00, 16'h0000);

		// phases favour enqueue, dequeue or neither, so the queue swings between full and empty
		while (n_sent < RAND_ITEMS + 25) begin
			case ($urandom_range(2))
				0: bias = 85;
				1: bias = 15;
				default: bias = 50;
			endcase
			run_len = $urandom_range(8, 40);
			repeat (run_len) begin
				idle_on <= !(n_sent >= 200 && n_sent < 330);
				func = ($urandom_range(99) < bias) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ;
				case ($urandom_range(3))
					0: prio = 8'($urandom_range(3));
					1: prio = 8'($urandom_range(255));
					2: prio = $urandom_range(1) ? 8'd255 : 8'd0;
					default: prio = 8'($urandom_range(250, 255));
				endcase
				send_op(func, prio, 16'($urandom_range(16'hffff)));
			end
		end
		in_valid <= 1'b0;

		// let the checker count the last transfer before waiting on it
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("run covered %0d operations, %0d results checked", n_sent, checked);
		$display("full-queue drops: %0d, empty-queue dequeues: %0d", drops, underflows);
		if (fail_count == 0 && pending == 0) begin
			$display("sorted_priority_queue_top: match");
		end else begin
			$display("sorted_priority_queue_top: mismatch");
		end
		$finish;
	end

endmodule
